>>> rtl/core/mbrce_pkg.sv
// ----------------------------------------------------------------------------
// mbrce_pkg
// Shared constants for the one-bit bitmap rotate/clip expander: register
// indexes, orientation codes and fixed field widths.
// ----------------------------------------------------------------------------
package mbrce_pkg;

  localparam int COORD_W      = 16;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int MODE_W       = 4;
  localparam int PIX_PER_BYTE = 8;

  localparam logic [31:0] EXTENT_RST = 32'h0000_8008;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_X_MAX = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_Y_MAX = 3'd7;

  localparam logic [2:0] ORI_IDENT     = 3'd0;
  localparam logic [2:0] ORI_ROT90     = 3'd1;
  localparam logic [2:0] ORI_ROT180    = 3'd2;
  localparam logic [2:0] ORI_ROT270    = 3'd3;
  localparam logic [2:0] ORI_MIRROR_X  = 3'd4;
  localparam logic [2:0] ORI_TRANSPOSE = 3'd5;
  localparam logic [2:0] ORI_MIRROR_Y  = 3'd6;
  localparam logic [2:0] ORI_ANTITRANS = 3'd7;

  localparam int MODE_CLIP_BIT = 3;

endpackage

>>> rtl/core/mbrce_front.sv
// ----------------------------------------------------------------------------
// mbrce_front
// Accept bitmap bytes, track row and column, drop bytes past the bitmap and
// issue one job per useful byte: pixel bits, bit count and offsets.
// ----------------------------------------------------------------------------
module mbrce_front #(
  parameter int SIZE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mbrce_pkg::BYTE_W-1:0]      in_byte,
  input  logic                              in_restart,
  input  logic [SIZE_BITS-1:0]              width,
  input  logic [SIZE_BITS-1:0]              height,
  output logic                              job_valid,
  input  logic                              job_ready,
  output logic [mbrce_pkg::BYTE_W+mbrce_pkg::CNT_W+4*SIZE_BITS-1:0] job_data
);
  import mbrce_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]    pixels;
    logic [CNT_W-1:0]     count;
    logic [SIZE_BITS-1:0] col;
    logic [SIZE_BITS-1:0] row;
    logic [SIZE_BITS-1:0] col_rem;
    logic [SIZE_BITS-1:0] row_rem;
  } job_t;

  logic [SIZE_BITS-1:0] row_r, row_nxt;
  logic [SIZE_BITS-1:0] col_r, col_nxt;
  logic [SIZE_BITS-1:0] row0, col0, row1, col1, rem;
  logic                 accept, adv, live;
  job_t                 job;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    row0    = in_restart ? '0 : row_r;
    col0    = in_restart ? '0 : col_r;
    adv     = (row0 < height) && (col0 >= width);
    row1    = adv ? row0 + SIZE_BITS'(1) : row0;
    col1    = adv ? '0 : col0;
    rem     = width - col1;
    live    = (width != '0) && (row1 < height);
    row_nxt = row_r;
    col_nxt = col_r;
    job.pixels  = in_byte;
    job.col     = col1;
    job.row     = row1;
    job.col_rem = rem;
    job.row_rem = height - row1;
    job.count   = CNT_W'(PIX_PER_BYTE);
    if (rem <= SIZE_BITS'(PIX_PER_BYTE)) begin
      job.count = rem[CNT_W-1:0];
    end
    if (accept) begin
      if (width == '0) begin
        row_nxt = row0;
        col_nxt = col0;
      end else if (!live) begin
        row_nxt = row1;
        col_nxt = col1;
      end else if (rem <= SIZE_BITS'(PIX_PER_BYTE)) begin
        row_nxt = row1 + SIZE_BITS'(1);
        col_nxt = '0;
      end else begin
        row_nxt = row1;
        col_nxt = col1 + SIZE_BITS'(PIX_PER_BYTE);
      end
    end
  end

  assign job_valid = in_valid && live;
  assign job_data  = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

>>> rtl/core/mbrce_queue.sv
// ----------------------------------------------------------------------------
// mbrce_queue
// Two-entry job queue between the byte front end and the pixel back end.
// ----------------------------------------------------------------------------
module mbrce_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

endmodule

>>> rtl/core/mbrce_back.sv
// ----------------------------------------------------------------------------
// mbrce_back
// Walk the bits of one job, one per cycle unless the output or a flush holds
// the walk: map, translate and clip each set pixel, and hold the newest kept
// pixel until the next one or the end of the byte decides its last flag.
// ----------------------------------------------------------------------------
module mbrce_back #(
  parameter int SIZE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              job_valid,
  output logic                              job_ready,
  input  logic [mbrce_pkg::BYTE_W+mbrce_pkg::CNT_W+4*SIZE_BITS-1:0] job_data,
  input  logic [mbrce_pkg::MODE_W-1:0]      mode,
  input  logic signed [mbrce_pkg::COORD_W-1:0] origin_x,
  input  logic signed [mbrce_pkg::COORD_W-1:0] origin_y,
  input  logic signed [mbrce_pkg::COORD_W-1:0] clip_x_min,
  input  logic signed [mbrce_pkg::COORD_W-1:0] clip_x_max,
  input  logic signed [mbrce_pkg::COORD_W-1:0] clip_y_min,
  input  logic signed [mbrce_pkg::COORD_W-1:0] clip_y_max,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbrce_pkg::COORD_W-1:0]     out_x,
  output logic [mbrce_pkg::COORD_W-1:0]     out_y,
  output logic                              out_last
);
  import mbrce_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0]    pixels;
    logic [CNT_W-1:0]     count;
    logic [SIZE_BITS-1:0] col;
    logic [SIZE_BITS-1:0] row;
    logic [SIZE_BITS-1:0] col_rem;
    logic [SIZE_BITS-1:0] row_rem;
  } job_t;

  job_t                        job;
  logic                        busy_r, busy_nxt;
  logic [BYTE_W-1:0]           pix_r, pix_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [SIZE_BITS-1:0]        col_r, col_nxt, colrem_r, colrem_nxt;
  logic [SIZE_BITS-1:0]        row_r, row_nxt, rowrem_r, rowrem_nxt;
  logic                        pend_v_r, pend_v_nxt, pend_fin_r, pend_fin_nxt;
  logic [COORD_W-1:0]          pend_x_r, pend_x_nxt, pend_y_r, pend_y_nxt;
  logic                        out_v_r, out_v_nxt, out_last_r, out_last_nxt;
  logic [COORD_W-1:0]          out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic [SIZE_BITS-1:0]        ox, oy;
  logic signed [COORD_W-1:0]   px, py;
  logic                        out_free, flush, step, eob, kept, inside_win, pop;

  assign job      = job_t'(job_data);
  assign out_free = !out_v_r || out_ready;
  assign flush    = pend_v_r && pend_fin_r && out_free;
  assign step     = busy_r && out_free && !(pend_v_r && pend_fin_r);
  assign eob      = (cnt_r == CNT_W'(1));
  assign pop      = job_valid && (!busy_r || (step && eob));
  assign job_ready = !busy_r || (step && eob);

  always_comb begin
    case (mode[2:0])
      ORI_IDENT:     begin ox = col_r;    oy = row_r;    end
      ORI_ROT90:     begin ox = row_r;    oy = colrem_r; end
      ORI_ROT180:    begin ox = colrem_r; oy = rowrem_r; end
      ORI_ROT270:    begin ox = rowrem_r; oy = col_r;    end
      ORI_MIRROR_X:  begin ox = colrem_r; oy = row_r;    end
      ORI_TRANSPOSE: begin ox = row_r;    oy = col_r;    end
      ORI_MIRROR_Y:  begin ox = col_r;    oy = rowrem_r; end
      default:       begin ox = rowrem_r; oy = colrem_r; end
    endcase
    px = origin_x + $signed(COORD_W'(ox));
    py = origin_y + $signed(COORD_W'(oy));
    inside_win = (px >= clip_x_min) && (px <= clip_x_max) &&
                 (py >= clip_y_min) && (py <= clip_y_max);
    kept = pix_r[BYTE_W-1] && (!mode[MODE_CLIP_BIT] || inside_win);
  end

  always_comb begin
    busy_nxt     = busy_r;
    pix_nxt      = pix_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    colrem_nxt   = colrem_r;
    row_nxt      = row_r;
    rowrem_nxt   = rowrem_r;
    pend_v_nxt   = pend_v_r;
    pend_fin_nxt = pend_fin_r;
    pend_x_nxt   = pend_x_r;
    pend_y_nxt   = pend_y_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_x_nxt    = out_x_r;
    out_y_nxt    = out_y_r;
    out_last_nxt = out_last_r;

    if (step) begin
      pix_nxt    = pix_r << 1;
      cnt_nxt    = cnt_r - CNT_W'(1);
      col_nxt    = col_r + SIZE_BITS'(1);
      colrem_nxt = colrem_r - SIZE_BITS'(1);
      if (eob) begin
        busy_nxt = 1'b0;
      end
    end
    if (pop) begin
      busy_nxt   = 1'b1;
      pix_nxt    = job.pixels;
      cnt_nxt    = job.count;
      col_nxt    = job.col;
      colrem_nxt = job.col_rem;
      row_nxt    = job.row;
      rowrem_nxt = job.row_rem;
    end

    if (flush) begin
      out_v_nxt    = 1'b1;
      out_x_nxt    = pend_x_r;
      out_y_nxt    = pend_y_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
      pend_fin_nxt = 1'b0;
    end else if (step) begin
      if (kept && pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_x_nxt    = pend_x_r;
        out_y_nxt    = pend_y_r;
        out_last_nxt = 1'b0;
        pend_x_nxt   = px;
        pend_y_nxt   = py;
        pend_fin_nxt = eob;
      end else if (kept && eob) begin
        out_v_nxt    = 1'b1;
        out_x_nxt    = px;
        out_y_nxt    = py;
        out_last_nxt = 1'b1;
      end else if (kept) begin
        pend_v_nxt   = 1'b1;
        pend_fin_nxt = 1'b0;
        pend_x_nxt   = px;
        pend_y_nxt   = py;
      end else if (eob && pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_x_nxt    = pend_x_r;
        out_y_nxt    = pend_y_r;
        out_last_nxt = 1'b1;
        pend_v_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    cnt_r      <= cnt_nxt;
    col_r      <= col_nxt;
    colrem_r   <= colrem_nxt;
    row_r      <= row_nxt;
    rowrem_r   <= rowrem_nxt;
    pend_x_r   <= pend_x_nxt;
    pend_y_r   <= pend_y_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      pend_v_r   <= 1'b0;
      pend_fin_r <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_fin_r <= pend_fin_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/core/mono_bitmap_rotate_clip_expander.sv
// ----------------------------------------------------------------------------
// mono_bitmap_rotate_clip_expander
// Expand a one-bit bitmap byte stream into screen pixel coordinates under one
// of eight orientations, with optional clipping to an inclusive window.
//
// Usage:
//   in_*  : one bitmap byte per transaction, MSB is the leftmost pixel;
//           in_tuser marks the first byte of a new bitmap.
//   out_* : one pixel coordinate per transaction; out_tlast flags the final
//           pixel kept for a byte. Bytes with no kept pixel give nothing.
//   cfg_* : register writes; the user writes only while the block is idle, unchecked.
// Ordering: a kept pixel waits for the next kept bit or the end of its byte,
//   which decides its last flag. Throughput: one pixel bit per cycle while
//   the output is not stalled; a byte walks up to 8 bits (the bits left in
//   the row), plus a flush step when its last kept pixel follows another
//   kept pixel. Bytes beyond the bitmap or with zero width are consumed
//   without issuing a job. A two-entry job queue lets the front take bytes
//   while pixels drain.
// Reset: row and column return to zero, the queue empties and registers
//   take their reset values; no clearing pass is needed.
// Stall: out_tready low holds the output; the back end then stops and the
//   queue fills, after which in_tready drops.
// ----------------------------------------------------------------------------
module mono_bitmap_rotate_clip_expander #(
  parameter int SIZE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] bitmap_byte
  input  logic                                in_tuser,   // [0] restart
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // [15:0] pixel_x, [31:16] pixel_y
  output logic                                out_tlast,
  input  logic                                cfg_wen,
  input  logic [mbrce_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mbrce_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mbrce_pkg::*;

  localparam int JOB_W = BYTE_W + CNT_W + 4 * SIZE_BITS;
  localparam logic [2*SIZE_BITS-1:0] EXT_RST = (2*SIZE_BITS)'(EXTENT_RST);

  logic [MODE_W-1:0]          mode_r;
  logic signed [COORD_W-1:0]  org_x_r, org_y_r;
  logic signed [COORD_W-1:0]  clip_x_min_r, clip_x_max_r, clip_y_min_r, clip_y_max_r;
  logic [SIZE_BITS-1:0]       width_r, height_r;
  logic [2*SIZE_BITS-1:0]     ext_val;

  logic                       fq_valid, fq_ready, qb_valid, qb_ready;
  logic [JOB_W-1:0]           fq_data, qb_data;
  logic [COORD_W-1:0]         pix_x, pix_y;

  assign ext_val = (2*SIZE_BITS)'(cfg_wdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= '0;
      org_x_r      <= '0;
      org_y_r      <= '0;
      width_r      <= EXT_RST[SIZE_BITS-1:0];
      height_r     <= EXT_RST[2*SIZE_BITS-1:SIZE_BITS];
      clip_x_min_r <= 16'sh8000;
      clip_x_max_r <= 16'sh7FFF;
      clip_y_min_r <= 16'sh8000;
      clip_y_max_r <= 16'sh7FFF;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_MODE:       mode_r       <= cfg_wdata[MODE_W-1:0];
        REG_ORIGIN_X:   org_x_r      <= cfg_wdata[COORD_W-1:0];
        REG_ORIGIN_Y:   org_y_r      <= cfg_wdata[COORD_W-1:0];
        REG_EXTENT: begin
          width_r  <= ext_val[SIZE_BITS-1:0];
          height_r <= ext_val[2*SIZE_BITS-1:SIZE_BITS];
        end
        REG_CLIP_X_MIN: clip_x_min_r <= cfg_wdata[COORD_W-1:0];
        REG_CLIP_X_MAX: clip_x_max_r <= cfg_wdata[COORD_W-1:0];
        REG_CLIP_Y_MIN: clip_y_min_r <= cfg_wdata[COORD_W-1:0];
        REG_CLIP_Y_MAX: clip_y_max_r <= cfg_wdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  mbrce_front #(.SIZE_BITS(SIZE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_restart (in_tuser),
    .width      (width_r),
    .height     (height_r),
    .job_valid  (fq_valid),
    .job_ready  (fq_ready),
    .job_data   (fq_data)
  );

  mbrce_queue #(.WIDTH(JOB_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  mbrce_back #(.SIZE_BITS(SIZE_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (qb_valid),
    .job_ready  (qb_ready),
    .job_data   (qb_data),
    .mode       (mode_r),
    .origin_x   (org_x_r),
    .origin_y   (org_y_r),
    .clip_x_min (clip_x_min_r),
    .clip_x_max (clip_x_max_r),
    .clip_y_min (clip_y_min_r),
    .clip_y_max (clip_y_max_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_x      (pix_x),
    .out_y      (pix_y),
    .out_last   (out_tlast)
  );

  assign out_tdata = {pix_y, pix_x};

endmodule

>>> rtl/core/mbrce_checker.sv
// ----------------------------------------------------------------------------
// mbrce_checker
// Port-level checks for the bitmap expander, bound to the top level.
// ----------------------------------------------------------------------------
module mbrce_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_reset_frees_input: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output transaction changed");

endmodule

bind mono_bitmap_rotate_clip_expander mbrce_checker u_mbrce_checker (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: bitmap expander stream check
// A directed table covers both reset corners, every orientation, zero width,
// a finished bitmap, a width cut mid-row and an inverted clip window. Random
// bitmaps with random sizes, origins and windows follow. Each pixel out is
// checked against an in-bench shadow of the row/column walk or a fixed pixel.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mbrce_pkg::*;

  localparam int SB          = 12;
  localparam int ITEM_TARGET = 330;
  localparam int TAIL_CYCLES = 40;
  localparam int DRAIN_LIMIT = 4000;
  localparam logic [3:0] CLIP_EN = 4'b1 << MODE_CLIP_BIT;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        last;
  } pixel_t;

  typedef enum logic [1:0] {ST_CFG, ST_PRED, ST_ONE, ST_NONE} step_kind_e;

  typedef struct {
    step_kind_e            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  rs;
    logic [15:0]           ex;
    logic [15:0]           ey;
  } step_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // shadow registers and walk state
  logic [3:0]         mode_r   = '0;
  logic [15:0]        org_x    = '0;
  logic [15:0]        org_y    = '0;
  logic [23:0]        extent_r = 24'h008008;
  logic signed [15:0] clip_xlo = 16'sh8000;
  logic signed [15:0] clip_xhi = 16'sh7FFF;
  logic signed [15:0] clip_ylo = 16'sh8000;
  logic signed [15:0] clip_yhi = 16'sh7FFF;
  logic [SB-1:0]      row_idx  = '0;
  logic [SB-1:0]      col_idx  = '0;

  pixel_t pix_q[$];
  pixel_t fresh_pix[$];
  int     errors    = 0;
  int     loaded    = 0;
  bit     src_gaps  = 1'b1;
  bit     sink_gaps = 1'b1;
  int     stall_left = 0;

  mono_bitmap_rotate_clip_expander #(.SIZE_BITS(SB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] bitmap_byte
    .in_tuser   (in_tuser),   // [0] restart
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [15:0] pixel_x, [31:16] pixel_y
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
    errors++;
  endtask

  // expand one byte into fresh_pix; returns 0 when the byte is ignored
  function automatic bit expand_byte(input logic [7:0] b, input logic rs);
    logic [SB-1:0]      w;
    logic [SB-1:0]      h;
    logic [15:0]        ox;
    logic [15:0]        oy;
    logic signed [15:0] px;
    logic signed [15:0] py;
    pixel_t             p;
    w = extent_r[SB-1:0];
    h = extent_r[2*SB-1:SB];
    fresh_pix.delete();
    if (rs) begin
      row_idx = '0;
      col_idx = '0;
    end
    if (w == 0) return 1'b0;
    if (row_idx < h && col_idx >= w) begin
      row_idx = row_idx + 1'b1;
      col_idx = '0;
    end
    if (row_idx >= h) return 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (b[7-k]) begin
        case (mode_r[2:0])
          ORI_IDENT:     begin ox = 16'(col_idx);     oy = 16'(row_idx);     end
          ORI_ROT90:     begin ox = 16'(row_idx);     oy = 16'(w - col_idx); end
          ORI_ROT180:    begin ox = 16'(w - col_idx); oy = 16'(h - row_idx); end
          ORI_ROT270:    begin ox = 16'(h - row_idx); oy = 16'(col_idx);     end
          ORI_MIRROR_X:  begin ox = 16'(w - col_idx); oy = 16'(row_idx);     end
          ORI_TRANSPOSE: begin ox = 16'(row_idx);     oy = 16'(col_idx);     end
          ORI_MIRROR_Y:  begin ox = 16'(col_idx);     oy = 16'(h - row_idx); end
          default:       begin ox = 16'(h - row_idx); oy = 16'(w - col_idx); end
        endcase
        px = org_x + ox;
        py = org_y + oy;
        if (!mode_r[MODE_CLIP_BIT] ||
            (px >= clip_xlo && px <= clip_xhi && py >= clip_ylo && py <= clip_yhi)) begin
          p.x    = px;
          p.y    = py;
          p.last = 1'b0;
          fresh_pix.push_back(p);
        end
      end
      col_idx = col_idx + 1'b1;
      if (col_idx >= w) begin
        row_idx = row_idx + 1'b1;
        col_idx = '0;
        break;
      end
    end
    if (fresh_pix.size() > 0) fresh_pix[fresh_pix.size()-1].last = 1'b1;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_MODE:       mode_r   = v[3:0];
      REG_ORIGIN_X:   org_x    = v[15:0];
      REG_ORIGIN_Y:   org_y    = v[15:0];
      REG_EXTENT:     extent_r = v;
      REG_CLIP_X_MIN: clip_xlo = v[15:0];
      REG_CLIP_X_MAX: clip_xhi = v[15:0];
      REG_CLIP_Y_MIN: clip_ylo = v[15:0];
      default:        clip_yhi = v[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic rs, input step_kind_e kind,
                          input logic [15:0] ex, input logic [15:0] ey, output bit counted);
    pixel_t one;
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= rs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    counted = expand_byte(b, rs);
    case (kind)
      ST_ONE: begin
        one.x    = ex;
        one.y    = ey;
        one.last = 1'b1;
        pix_q.push_back(one);
      end
      ST_NONE: ;
      default: foreach (fresh_pix[k]) pix_q.push_back(fresh_pix[k]);
    endcase
  endtask

  // drop valid, wait for every pending pixel, then let the queue empty
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pix_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (pix_q.size() != 0) begin
      report_mismatch("pixels never delivered", pix_q.size(), 32'd0);
      pix_q.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'h7FF0 + 16'($urandom_range(0, 15));
      2:       return 16'h8000 + 16'($urandom_range(0, 15));
      default: return 16'($urandom_range(0, 40)) - 16'd20;
    endcase
  endfunction

  function automatic logic [7:0] rand_pixels();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic random_phase();
    logic [SB-1:0] w;
    logic [SB-1:0] h;
    logic [15:0]   ox;
    logic [15:0]   oy;
    logic [15:0]   xlo;
    logic [15:0]   ylo;
    int            nbytes;
    int            breakat;
    bit            lead_rs;
    bit            counted;
    case ($urandom_range(0, 19))
      0:       w = '0;
      1:       w = '1;
      2:       w = SB'($urandom_range(1, 4095));
      default: w = SB'($urandom_range(1, 20));
    endcase
    case ($urandom_range(0, 19))
      0:       h = '0;
      1:       h = '1;
      default: h = SB'($urandom_range(1, 5));
    endcase
    ox = rand_coord();
    oy = rand_coord();
    write_reg(REG_MODE, CFG_DATA_W'($urandom_range(0, 15)));
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    write_reg(REG_EXTENT, {h, w});
    case ($urandom_range(0, 3))
      0: begin
        write_reg(REG_CLIP_X_MIN, 24'h008000);
        write_reg(REG_CLIP_X_MAX, 24'h007FFF);
        write_reg(REG_CLIP_Y_MIN, 24'h008000);
        write_reg(REG_CLIP_Y_MAX, 24'h007FFF);
      end
      1: begin
        write_reg(REG_CLIP_X_MIN, CFG_DATA_W'($urandom));
        write_reg(REG_CLIP_X_MAX, CFG_DATA_W'($urandom));
        write_reg(REG_CLIP_Y_MIN, CFG_DATA_W'($urandom));
        write_reg(REG_CLIP_Y_MAX, CFG_DATA_W'($urandom));
      end
      default: begin
        xlo = ox + 16'($urandom_range(0, 6));
        ylo = oy + 16'($urandom_range(0, 4));
        write_reg(REG_CLIP_X_MIN, CFG_DATA_W'(xlo));
        write_reg(REG_CLIP_X_MAX, CFG_DATA_W'(xlo + 16'($urandom_range(0, 12))));
        write_reg(REG_CLIP_Y_MIN, CFG_DATA_W'(ylo));
        write_reg(REG_CLIP_Y_MAX, CFG_DATA_W'(ylo + 16'($urandom_range(0, 6))));
      end
    endcase
    src_gaps  = (loaded < ITEM_TARGET - 60) && ($urandom_range(0, 3) != 0);
    sink_gaps = (loaded < ITEM_TARGET - 60) && ($urandom_range(0, 3) != 0);
    nbytes = ((int'(w) + 7) / 8) * int'(h);
    if (nbytes > 32) nbytes = 32;
    nbytes += $urandom_range(0, 2);
    breakat = ($urandom_range(0, 7) == 0) ? $urandom_range(1, nbytes + 1) : -1;
    lead_rs = ($urandom_range(0, 7) != 0);
    for (int k = 0; k < nbytes; k++) begin
      put_byte(rand_pixels(), (k == 0 && lead_rs) || k == breakat, ST_PRED, '0, '0, counted);
      if (counted) loaded++;
    end
    settle();
  endtask

  always @(posedge clk) begin
    if (!sink_gaps) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pix_q.size() == 0) begin
        report_mismatch("pixel with none pending", 32'd0, out_tdata);
      end else begin
        want = pix_q.pop_front();
        if (out_tdata[15:0] !== want.x) begin
          report_mismatch("pixel_x", 32'(want.x), 32'(out_tdata[15:0]));
        end
        if (out_tdata[31:16] !== want.y) begin
          report_mismatch("pixel_y", 32'(want.y), 32'(out_tdata[31:16]));
        end
        if (out_tlast !== want.last) begin
          report_mismatch("last", 32'(want.last), 32'(out_tlast));
        end
      end
    end
  end

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] v);
    step_t s;
    s.kind = ST_CFG;
    s.idx  = idx;
    s.val  = v;
    s.rs   = 1'b0;
    s.ex   = '0;
    s.ey   = '0;
    return s;
  endfunction

  function automatic step_t byte_row(input step_kind_e kind, input logic [7:0] b,
                                     input logic rs, input logic [15:0] ex,
                                     input logic [15:0] ey);
    step_t s;
    s.kind = kind;
    s.idx  = REG_MODE;
    s.val  = CFG_DATA_W'(b);
    s.rs   = rs;
    s.ex   = ex;
    s.ey   = ey;
    return s;
  endfunction

  initial begin : stimulus
    step_t plan[$];
    bit    counted;
    bit    streaming;
    streaming = 1'b0;
    // reset values: 8x8, identity, origin 0, full window
    plan.push_back(byte_row(ST_ONE,  8'h80, 1'b1, 16'd0, 16'd0));
    plan.push_back(byte_row(ST_ONE,  8'h01, 1'b0, 16'd7, 16'd1));
    plan.push_back(byte_row(ST_NONE, 8'h00, 1'b0, '0, '0));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b0, '0, '0));
    // 5x3 rotated by 180 at the coordinate extremes, wrapping
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(CLIP_EN | ORI_ROT180)));
    plan.push_back(cfg_row(REG_ORIGIN_X, 24'h007FFF));
    plan.push_back(cfg_row(REG_ORIGIN_Y, 24'h008000));
    plan.push_back(cfg_row(REG_EXTENT, 24'h003005));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b1, '0, '0));
    plan.push_back(byte_row(ST_PRED, 8'hA5, 1'b0, '0, '0));
    plan.push_back(byte_row(ST_PRED, 8'h5A, 1'b0, '0, '0));
    plan.push_back(byte_row(ST_NONE, 8'hFF, 1'b0, '0, '0));
    // zero width
    plan.push_back(cfg_row(REG_EXTENT, 24'h003000));
    plan.push_back(byte_row(ST_NONE, 8'hFF, 1'b1, '0, '0));
    // largest extent
    plan.push_back(cfg_row(REG_EXTENT, 24'hFFFFFF));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_ANTITRANS)));
    plan.push_back(cfg_row(REG_ORIGIN_X, 24'h000000));
    plan.push_back(cfg_row(REG_ORIGIN_Y, 24'h000000));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b1, '0, '0));
    plan.push_back(byte_row(ST_PRED, 8'h81, 1'b0, '0, '0));
    // width cut below the column mid-row
    plan.push_back(cfg_row(REG_EXTENT, 24'h002010));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_ROT90)));
    plan.push_back(byte_row(ST_PRED, 8'hC3, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_EXTENT, 24'h002005));
    plan.push_back(byte_row(ST_PRED, 8'hF0, 1'b0, '0, '0));
    plan.push_back(byte_row(ST_NONE, 8'hFF, 1'b0, '0, '0));
    // inverted window, then a narrow one
    plan.push_back(cfg_row(REG_EXTENT, 24'h008008));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(CLIP_EN | ORI_IDENT)));
    plan.push_back(cfg_row(REG_CLIP_X_MIN, 24'h00000A));
    plan.push_back(cfg_row(REG_CLIP_X_MAX, 24'h000005));
    plan.push_back(byte_row(ST_NONE, 8'hFF, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_CLIP_X_MIN, 24'h000002));
    plan.push_back(cfg_row(REG_CLIP_X_MAX, 24'h000005));
    plan.push_back(cfg_row(REG_CLIP_Y_MIN, 24'h00FFFF));
    plan.push_back(cfg_row(REG_CLIP_Y_MAX, 24'h000000));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b1, '0, '0));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b0, '0, '0));
    plan.push_back(cfg_row(REG_CLIP_X_MIN, 24'h008000));
    plan.push_back(cfg_row(REG_CLIP_X_MAX, 24'h007FFF));
    plan.push_back(cfg_row(REG_CLIP_Y_MIN, 24'h008000));
    plan.push_back(cfg_row(REG_CLIP_Y_MAX, 24'h007FFF));
    // remaining orientations
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_ROT270)));
    plan.push_back(byte_row(ST_PRED, 8'h55, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_MIRROR_X)));
    plan.push_back(byte_row(ST_PRED, 8'hAA, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_TRANSPOSE)));
    plan.push_back(byte_row(ST_PRED, 8'h3C, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_MODE, CFG_DATA_W'(ORI_MIRROR_Y)));
    plan.push_back(byte_row(ST_PRED, 8'hFF, 1'b1, '0, '0));
    plan.push_back(cfg_row(REG_MODE, 24'h00000F));
    plan.push_back(byte_row(ST_PRED, 8'h7E, 1'b1, '0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ST_CFG) begin
        if (streaming) settle();
        streaming = 1'b0;
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        streaming = 1'b1;
        put_byte(plan[k].val[7:0], plan[k].rs, plan[k].kind, plan[k].ex, plan[k].ey, counted);
        if (counted) loaded++;
      end
    end
    settle();

    while (loaded < ITEM_TARGET) random_phase();

    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    settle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
